// ===== sv/rbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

  // Number of entries in the circular store.
  localparam int unsigned DEPTH = 128;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned FUNC_W        = 3;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned ENTRY_COUNT_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_PEEK_FRONT = 3'd4,
    FUNC_PEEK_BACK  = 3'd5
  } rbd_func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } rbd_status_e;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] push_value;
  } rbd_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]   read_value;
    logic [STATUS_W-1:0]        status;
    logic [ENTRY_COUNT_W-1:0]   entry_count;
  } rbd_out_t;

  // One access to the entry store.
  typedef struct packed {
    logic              en;
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] wdata;
  } rbd_mem_cmd_t;

  // Result fields known at the time an item is accepted.
  typedef struct packed {
    logic                     is_read;
    logic [STATUS_W-1:0]      status;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } rbd_res_t;

endpackage

`default_nettype wire

// ===== sv/rbd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rbd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single port; read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/rbd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rbd_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fire_i,
  input  wire rbd_pkg::rbd_in_t      item_i,
  output rbd_pkg::rbd_mem_cmd_t      mem_cmd_o,
  output rbd_pkg::rbd_res_t          res_o
);

  import rbd_pkg::*;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
  endfunction

  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic             full, empty;
  logic [IDX_W-1:0] head_prev, tail_prev;
  rbd_mem_cmd_t     cmd;

  assign full      = (occ_q == CNT_W'(DEPTH));
  assign empty     = (occ_q == '0);
  assign head_prev = wrap_dec(head_q);
  assign tail_prev = wrap_dec(tail_q);

  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    occ_d         = occ_q;
    cmd.en        = 1'b0;
    cmd.we        = 1'b0;
    cmd.addr      = head_q;
    cmd.wdata     = item_i.push_value;
    res_o.is_read = 1'b0;
    res_o.status  = STATUS_DONE;

    unique case (item_i.func)
      FUNC_PUSH_FRONT: begin
        if (full) begin
          res_o.status = STATUS_FULL;
        end else begin
          head_d   = head_prev;
          occ_d    = occ_q + 1'b1;
          cmd.en   = 1'b1;
          cmd.we   = 1'b1;
          cmd.addr = head_prev;
        end
      end
      FUNC_PUSH_BACK: begin
        if (full) begin
          res_o.status = STATUS_FULL;
        end else begin
          tail_d   = wrap_inc(tail_q);
          occ_d    = occ_q + 1'b1;
          cmd.en   = 1'b1;
          cmd.we   = 1'b1;
          cmd.addr = tail_q;
        end
      end
      FUNC_POP_FRONT, FUNC_PEEK_FRONT: begin
        if (empty) begin
          res_o.status = STATUS_EMPTY;
        end else begin
          cmd.en        = 1'b1;
          cmd.addr      = head_q;
          res_o.is_read = 1'b1;
          if (item_i.func == FUNC_POP_FRONT) begin
            head_d = wrap_inc(head_q);
            occ_d  = occ_q - 1'b1;
          end
        end
      end
      FUNC_POP_BACK, FUNC_PEEK_BACK: begin
        if (empty) begin
          res_o.status = STATUS_EMPTY;
        end else begin
          cmd.en        = 1'b1;
          cmd.addr      = tail_prev;
          res_o.is_read = 1'b1;
          if (item_i.func == FUNC_POP_BACK) begin
            tail_d = tail_prev;
            occ_d  = occ_q - 1'b1;
          end
        end
      end
      default: begin
        // Unused codes leave everything unchanged.
      end
    endcase

    res_o.entry_count = ENTRY_COUNT_W'(occ_d);
    mem_cmd_o         = cmd;
    mem_cmd_o.en      = cmd.en & fire_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
    end else if (fire_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ring_buffer_deque.sv =====
// Double-ended queue of DEPTH 32-bit words in a single-port circular store.
// Each item carries an operation (push or pop at either end, or peek at
// either end) and a data word, and yields exactly one result item with the
// word read, a status and the entry count after the operation. A push to a
// full queue is dropped with status full; a pop or peek on an empty queue
// returns zero with status empty. The block takes one item per cycle: the
// head and tail pointers and the count are updated in the cycle an item is
// accepted, the store is accessed in that same cycle, and the result is
// presented from the output register and the store's read register in the
// next cycle. A new item is taken whenever the output register is free or
// is being emptied in that cycle, so an item is accepted at every edge
// while the consumer keeps ready high. No clearing pass is needed after
// reset, because only entries that hold pushed words are ever read.
`timescale 1ns / 1ps
`default_nettype none

module ring_buffer_deque (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rbd_pkg::rbd_in_t  in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rbd_pkg::rbd_out_t      out_item_o
);

  import rbd_pkg::*;

  logic              fire;
  logic              out_valid_q;
  rbd_res_t          res;
  rbd_res_t          res_q;
  rbd_mem_cmd_t      mem_cmd;
  logic [WORD_W-1:0] rdata;

  // The store's read register only changes on an accepted read, which can
  // happen only when the current result leaves, so it doubles as the
  // output data register.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  rbd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (in_item_i),
    .mem_cmd_o (mem_cmd),
    .res_o     (res)
  );

  rbd_ram #(
    .Width (WORD_W),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_cmd.en),
    .we_i    (mem_cmd.we),
    .addr_i  (mem_cmd.addr),
    .wdata_i (mem_cmd.wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result fields other than the read word are settled at acceptance.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_item_o.read_value  = res_q.is_read ? $signed(rdata) : '0;
  assign out_item_o.status      = res_q.status;
  assign out_item_o.entry_count = res_q.entry_count;

endmodule

`default_nettype wire

// ===== bench/ring_buffer_deque_chk.sv =====
`timescale 1ns / 1ps

module ring_buffer_deque_chk (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_i,
  input  wire rbd_pkg::rbd_in_t  in_item_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i,
  input  wire rbd_pkg::rbd_out_t out_item_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  import rbd_pkg::*;

  // Shadow copy of the queue.
  logic [WORD_W-1:0] shadow_words [DEPTH];
  logic [IDX_W-1:0]  front_slot;
  logic [IDX_W-1:0]  back_slot;
  logic [CNT_W-1:0]  held;

  rbd_out_t due_results[$];
  int       mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic logic [IDX_W-1:0] slot_next(logic [IDX_W-1:0] s);
    return (s == IDX_W'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] slot_prev(logic [IDX_W-1:0] s);
    return (s == '0) ? IDX_W'(DEPTH - 1) : s - 1'b1;
  endfunction

  // Applies one operation to the shadow queue and returns the result item.
  function automatic rbd_out_t apply_deque_op(rbd_in_t item);
    rbd_out_t         res;
    logic [IDX_W-1:0] last;
    res = '0;
    res.status = STATUS_DONE;
    case (item.func)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (held == CNT_W'(DEPTH)) begin
          res.status = STATUS_FULL;
        end else if (item.func == FUNC_PUSH_FRONT) begin
          front_slot = slot_prev(front_slot);
          shadow_words[front_slot] = item.push_value;
          held = held + 1'b1;
        end else begin
          shadow_words[back_slot] = item.push_value;
          back_slot = slot_next(back_slot);
          held = held + 1'b1;
        end
      end
      FUNC_POP_FRONT, FUNC_PEEK_FRONT: begin
        if (held == '0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.read_value = shadow_words[front_slot];
          if (item.func == FUNC_POP_FRONT) begin
            front_slot = slot_next(front_slot);
            held = held - 1'b1;
          end
        end
      end
      FUNC_POP_BACK, FUNC_PEEK_BACK: begin
        if (held == '0) begin
          res.status = STATUS_EMPTY;
        end else begin
          last = slot_prev(back_slot);
          res.read_value = shadow_words[last];
          if (item.func == FUNC_POP_BACK) begin
            back_slot = last;
            held = held - 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = ENTRY_COUNT_W'(held);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rbd_out_t want;
    if (!rst_ni) begin
      front_slot = '0;
      back_slot  = '0;
      held       = '0;
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        due_results.insert(due_results.size(), apply_deque_op(in_item_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result item: read_value %0d status %0d entry_count %0d",
                 out_item_i.read_value, out_item_i.status, out_item_i.entry_count);
          mismatches++;
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (out_item_i.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value,
                   out_item_i.read_value);
            mismatches++;
          end
          if (out_item_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item_i.status);
            mismatches++;
          end
          if (out_item_i.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_item_i.entry_count);
            mismatches++;
          end
        end
      end
      pending_o <= due_results.size();
    end
  end

endmodule

// ===== bench/ring_buffer_deque_tb.sv =====
`timescale 1ns / 1ps

module ring_buffer_deque_tb;
  import rbd_pkg::*;

  localparam int CLK_PERIOD = 20;

  // Operation codes that the block treats as no-ops.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MIN  = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX  = 32'sh7fff_ffff;
  localparam logic signed [WORD_W-1:0] WORD_ZERO = 32'sh0000_0000;
  localparam logic signed [WORD_W-1:0] WORD_ONES = 32'shffff_ffff;

  // Ways in which the consumer throttles the result channel.
  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_EVERY_FOURTH,
    RDY_LONG_STALL
  } ready_mode_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  rbd_in_t  in_item_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  rbd_out_t out_item_o;

  int fail_count;
  int pending_items;
  int burst_left = 0;

  ready_mode_e ready_mode = RDY_ALWAYS;
  int          mode_left  = 0;

  ring_buffer_deque u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // The checker watches both channels, keeps its own copy of the queue and
  // compares every result item against the oldest outstanding prediction.
  ring_buffer_deque_chk u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_items)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // The consumer switches between stall patterns at random intervals. One of
  // them never stalls, so long stretches of back-to-back results occur too.
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(8, 60);
    end
    mode_left--;
    case (ready_mode)
      RDY_ALWAYS:       out_ready_i <= 1'b1;
      RDY_COIN:         out_ready_i <= ($urandom_range(0, 1) == 1);
      RDY_EVERY_FOURTH: out_ready_i <= (mode_left % 4 == 0);
      default:          out_ready_i <= (mode_left < 3);
    endcase
  end

  // Mostly random words, with the sign and range extremes mixed in.
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return WORD_ZERO;
      3:       return WORD_ONES;
      default: return $urandom;
    endcase
  endfunction

  // Offers one item and returns at the edge where it is accepted. The sender
  // works in bursts; between bursts valid may drop for a random number of cycles.
  // Valid is only lowered when a real gap follows, so it is never dropped and
  // raised again in the same time step.
  task automatic send_item(input logic [FUNC_W-1:0] op,
                           input logic signed [WORD_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{func: op, push_value: word};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
  endtask

  // Holds the sender off until every predicted result item has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_items != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  initial begin
    int pushes;
    int pops;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Every pop and peek on an empty queue must be flagged,
    // and the spare codes must leave the count alone.
    send_item(FUNC_POP_FRONT, WORD_MAX);
    send_item(FUNC_POP_BACK, WORD_MIN);
    send_item(FUNC_PEEK_FRONT, WORD_ZERO);
    send_item(FUNC_PEEK_BACK, WORD_ONES);
    send_item(FUNC_SPARE_6, WORD_ONES);
    send_item(FUNC_SPARE_7, WORD_MIN);

    // Extreme words at both ends; the queue then reads 0, max, min, -1.
    send_item(FUNC_PUSH_FRONT, WORD_MAX);
    send_item(FUNC_PUSH_BACK, WORD_MIN);
    send_item(FUNC_PUSH_FRONT, WORD_ZERO);
    send_item(FUNC_PUSH_BACK, WORD_ONES);
    send_item(FUNC_PEEK_FRONT, WORD_MAX);
    send_item(FUNC_PEEK_BACK, WORD_ZERO);
    send_item(FUNC_SPARE_6, 32'sh1234_5678);

    // Drain alternately from either end, then pop once more past empty.
    send_item(FUNC_POP_BACK, WORD_ZERO);
    send_item(FUNC_POP_FRONT, WORD_ZERO);
    send_item(FUNC_POP_BACK, WORD_ZERO);
    send_item(FUNC_POP_FRONT, WORD_ZERO);
    send_item(FUNC_POP_FRONT, WORD_ZERO);

    // A single entry is both front and back, whichever end it entered by.
    send_item(FUNC_PUSH_BACK, 32'sh5555_5555);
    send_item(FUNC_POP_FRONT, WORD_ZERO);
    send_item(FUNC_PUSH_FRONT, 32'shaaaa_aaaa);
    send_item(FUNC_POP_BACK, WORD_ZERO);

    wait_drained();

    // Fill phase: mostly pushes at a random end, enough to pass full so that
    // the dropped-push case is reached and the pointers wrap.
    pushes = 0;
    while (pushes < DEPTH + 12) begin
      if ($urandom_range(0, 9) != 0) begin
        send_item($urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, pick_word());
        pushes++;
      end else begin
        send_item(FUNC_W'($urandom_range(2, 7)), pick_word());
      end
    end

    // The sender pauses here until every result has been returned.
    wait_drained();

    // Mixed phase: any code, any word, starting from a full queue.
    repeat (100) send_item(FUNC_W'($urandom_range(0, 7)), pick_word());

    // Drain phase: mostly pops at a random end, running past empty.
    pops = 0;
    while (pops < DEPTH + 12) begin
      if ($urandom_range(0, 9) != 0) begin
        send_item($urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT, pick_word());
        pops++;
      end else begin
        send_item(FUNC_W'($urandom_range(0, 7)), pick_word());
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ring_buffer_deque_tb: done, clean");
    end else begin
      $display("ring_buffer_deque_tb: done, errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("ring_buffer_deque_tb: done, errors");
    $finish;
  end

endmodule

// ===== ring_buffer_deque.f =====
sv/rbd_pkg.sv
sv/rbd_ram.sv
sv/rbd_ctrl.sv
sv/ring_buffer_deque.sv
bench/ring_buffer_deque_chk.sv
bench/ring_buffer_deque_tb.sv
